[hw/rtl/fdsd_pkg.sv]
// Face-down and shake detector package: item, result, config and state types.
// Used by fdsd_calc and the top level. No dependencies.
`timescale 1ns / 1ps

package fdsd_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic [31:0]        sample_time_ms;
    logic               napping_in;
  } item_t;

  typedef struct packed {
    logic        face_down;
    logic        nap_start;
    logic        nap_end;
    logic [31:0] nap_end_time_ms;
    logic        shake_seen;
    logic [31:0] dizzy_deadline_ms;
  } result_t;

  typedef struct packed {
    logic signed [15:0] face_down_limit;
    logic [15:0]        nap_hold_ms;
    logic [31:0]        shake_limit;
    logic [15:0]        dizzy_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0] down_start_time;
    logic        down_timing;
    logic        was_down;
  } state_t;

  typedef enum logic [1:0] {
    REG_FACE_DOWN_LIMIT = 2'd0,
    REG_NAP_HOLD_MS     = 2'd1,
    REG_SHAKE_LIMIT     = 2'd2,
    REG_DIZZY_HOLD_MS   = 2'd3
  } cfg_index_t;

  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 32;

  localparam logic signed [15:0] FACE_DOWN_LIMIT_RST = -16'sd5734;
  localparam logic [15:0]        NAP_HOLD_MS_RST     = 16'd5000;
  localparam logic [31:0]        SHAKE_LIMIT_RST     = 32'd268435456;
  localparam logic [15:0]        DIZZY_HOLD_MS_RST   = 16'd5000;

endpackage

[hw/rtl/fdsd_in_if.sv]
// Sample channel: valid/ready handshake with the accelerometer sample payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface fdsd_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic [31:0]        sample_time_ms;
  logic               napping_in;

  modport source (output valid, accel_x, accel_y, accel_z, sample_time_ms, napping_in,
                  input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, sample_time_ms, napping_in,
                  output ready);
endinterface

[hw/rtl/fdsd_out_if.sv]
// Result channel: valid/ready handshake with the detector result payload.
// Depends on nothing.
`timescale 1ns / 1ps

interface fdsd_out_if;
  logic        valid;
  logic        ready;
  logic        face_down;
  logic        nap_start;
  logic        nap_end;
  logic [31:0] nap_end_time_ms;
  logic        shake_seen;
  logic [31:0] dizzy_deadline_ms;

  modport source (output valid, face_down, nap_start, nap_end, nap_end_time_ms,
                  shake_seen, dizzy_deadline_ms, input ready);
  modport sink   (input valid, face_down, nap_start, nap_end, nap_end_time_ms,
                  shake_seen, dizzy_deadline_ms, output ready);
endinterface

[hw/rtl/face_down_and_shake_detector_core.sv]
// Top level of the face-down and shake detector: config registers, pipeline, state.
// Depends on fdsd_pkg, fdsd_in_if, fdsd_out_if and fdsd_calc.
`timescale 1ns / 1ps

// One sample is taken per clock unless the result register stalls: the
// sample lands in an input register, one pass of compare, three 16-bit squarers
// and the face-down timer logic fills the result register. The result register
// holds while the sink stalls, and the input register still takes a new sample
// as long as the result register frees up in the same cycle. Face-down timing
// state advances in sample order as each sample moves into the result register.
// Configuration writes take effect at once and are meant for idle periods.
module face_down_and_shake_detector_core (
  input  logic                                  clk,
  input  logic                                  rst,
  fdsd_in_if.sink                               in_ch,
  fdsd_out_if.source                            out_ch,
  input  logic                                  cfg_we,
  input  logic [fdsd_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [fdsd_pkg::CfgDataWidth-1:0]     cfg_data
);

  fdsd_pkg::cfg_t    cfg;
  fdsd_pkg::state_t  state;
  fdsd_pkg::state_t  state_next;
  fdsd_pkg::item_t   item;
  fdsd_pkg::item_t   item_in;
  fdsd_pkg::result_t result;
  fdsd_pkg::result_t result_next;
  logic              item_valid;
  logic              result_valid;
  logic              advance;
  logic              in_take;

  assign advance = item_valid && (!result_valid || out_ch.ready);
  assign in_take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !item_valid || advance;

  assign item_in.accel_x        = in_ch.accel_x;
  assign item_in.accel_y        = in_ch.accel_y;
  assign item_in.accel_z        = in_ch.accel_z;
  assign item_in.sample_time_ms = in_ch.sample_time_ms;
  assign item_in.napping_in     = in_ch.napping_in;

  fdsd_calc u_calc (
    .item       (item),
    .cfg        (cfg),
    .state      (state),
    .result     (result_next),
    .state_next (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.face_down_limit <= fdsd_pkg::FACE_DOWN_LIMIT_RST;
      cfg.nap_hold_ms     <= fdsd_pkg::NAP_HOLD_MS_RST;
      cfg.shake_limit     <= fdsd_pkg::SHAKE_LIMIT_RST;
      cfg.dizzy_hold_ms   <= fdsd_pkg::DIZZY_HOLD_MS_RST;
    end else if (cfg_we) begin
      case (fdsd_pkg::cfg_index_t'(cfg_index))
        fdsd_pkg::REG_FACE_DOWN_LIMIT: cfg.face_down_limit <= $signed(cfg_data[15:0]);
        fdsd_pkg::REG_NAP_HOLD_MS:     cfg.nap_hold_ms     <= cfg_data[15:0];
        fdsd_pkg::REG_SHAKE_LIMIT:     cfg.shake_limit     <= cfg_data;
        fdsd_pkg::REG_DIZZY_HOLD_MS:   cfg.dizzy_hold_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid   <= 1'b0;
      result_valid <= 1'b0;
      state        <= '0;
    end else begin
      if (in_take) begin
        item_valid <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
      if (advance) begin
        result_valid <= 1'b1;
        state        <= state_next;
      end else if (out_ch.ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item <= item_in;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign out_ch.valid             = result_valid;
  assign out_ch.face_down         = result.face_down;
  assign out_ch.nap_start         = result.nap_start;
  assign out_ch.nap_end           = result.nap_end;
  assign out_ch.nap_end_time_ms   = result.nap_end_time_ms;
  assign out_ch.shake_seen        = result.shake_seen;
  assign out_ch.dizzy_deadline_ms = result.dizzy_deadline_ms;

  // nap start needs face down, nap end needs its absence
  a_nap_vs_down: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.nap_start || result.face_down) &&
                     (!result.nap_end || !result.face_down))
    else $error("nap flag disagrees with face_down");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    !state.down_timing |-> (state.down_start_time == '0))
    else $error("down start time kept while not timing");

  a_timer_tracks_down: assert property (@(posedge clk) disable iff (rst)
    advance |=> (state.down_timing == state.was_down))
    else $error("timing flag out of step with face-down history");

  a_zero_when_clear: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.shake_seen || result.dizzy_deadline_ms == '0) &&
                     (result.nap_end || result.nap_end_time_ms == '0))
    else $error("time field set without its flag");

endmodule

[hw/rtl/fdsd_calc.sv]
// Per-sample logic: face-down timing, nap start/end, squared magnitude and shake.
// Depends on fdsd_pkg.
`timescale 1ns / 1ps

module fdsd_calc (
  input  fdsd_pkg::item_t   item,
  input  fdsd_pkg::cfg_t    cfg,
  input  fdsd_pkg::state_t  state,
  output fdsd_pkg::result_t result,
  output fdsd_pkg::state_t  state_next
);

  logic signed [31:0] sq_x;
  logic signed [31:0] sq_y;
  logic signed [31:0] sq_z;
  logic [31:0]        mag2;
  logic               down;
  logic [31:0]        elapsed;
  logic               start;
  logic               nap_end;
  logic               shake;

  // each square is at most 2^30, so the sum of three fits 32 bits unsigned
  assign sq_x = item.accel_x * item.accel_x;
  assign sq_y = item.accel_y * item.accel_y;
  assign sq_z = item.accel_z * item.accel_z;
  assign mag2 = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);
  assign shake = mag2 > cfg.shake_limit;

  assign down    = item.accel_z < cfg.face_down_limit;
  assign elapsed = state.down_timing ? (item.sample_time_ms - state.down_start_time) : '0;
  assign start   = down && !item.napping_in && (elapsed > {16'd0, cfg.nap_hold_ms});
  assign nap_end = state.was_down && !down && item.napping_in;

  always_comb begin
    result.face_down         = down;
    result.nap_start         = start;
    result.nap_end           = nap_end;
    result.nap_end_time_ms   = nap_end ? item.sample_time_ms : '0;
    result.shake_seen        = shake;
    result.dizzy_deadline_ms = shake ? (item.sample_time_ms + {16'd0, cfg.dizzy_hold_ms}) : '0;

    state_next.was_down = down;
    if (down) begin
      state_next.down_timing     = 1'b1;
      state_next.down_start_time = state.down_timing ? state.down_start_time
                                                     : item.sample_time_ms;
    end else begin
      state_next.down_timing     = 1'b0;
      state_next.down_start_time = '0;
    end
  end

endmodule
